// File: src/byte_fifo_burst_flags_defines.svh
// assertion macros for the burst byte fifo
// no dependencies; included by the top level only
`ifndef BYTE_FIFO_BURST_FLAGS_DEFINES_SVH
`define BYTE_FIFO_BURST_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is high
`define FBF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define FBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBF_ASSERT(lbl, clk, rst, prop, msg)
`define FBF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/fbf_pkg.sv
// shared types and constants of the burst byte fifo
// no dependencies; used by the interfaces, the lanes, the merge stage and the top level
package fbf_pkg;

   localparam int DATA_W    = 64;
   localparam int BURST_W   = 4;
   localparam int FILL_W    = 9;
   localparam int MARGIN_W  = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 9;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = 1'b1;

   localparam logic [FILL_W-1:0]   DEPTH_RESET  = 9'd256;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd1;

   // request codes
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   // what the sequencer hands the merge stage at the end of an item
   typedef struct packed {
      op_type                op;
      logic [BURST_W-1:0]    done;
      logic [FILL_W-1:0]     fill;
      logic [FILL_W-1:0]     depth;
      logic [MARGIN_W-1:0]   margin;
      logic                  overrun;
      logic                  underrun;
   } status_type;

   // registered result item
   typedef struct packed {
      logic [DATA_W-1:0]     read_bytes;
      logic [BURST_W-1:0]    done_count;
      logic [FILL_W-1:0]     fill_level;
      logic                  not_full;
      logic                  not_almost_full;
      logic                  not_empty;
      logic                  not_almost_empty;
      logic                  overrun_flag;
      logic                  underrun_flag;
   } rsp_type;

endpackage

// File: src/fbf_req_if.sv
// request channel of the burst byte fifo: valid, ready and the request fields
// depends on fbf_pkg for the field widths
interface fbf_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [fbf_pkg::BURST_W-1:0]   byte_count;
   logic [fbf_pkg::DATA_W-1:0]    write_bytes;
   logic                          clear_overrun;
   logic                          clear_underrun;

   modport source (
      output valid, req_type, byte_count, write_bytes, clear_overrun, clear_underrun,
      input  ready
   );
   modport sink (
      input  valid, req_type, byte_count, write_bytes, clear_overrun, clear_underrun,
      output ready
   );
endinterface

// File: src/fbf_rsp_if.sv
// response channel of the burst byte fifo: valid, ready and the result fields
// depends on fbf_pkg for the field widths
interface fbf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbf_pkg::DATA_W-1:0]    read_bytes;
   logic [fbf_pkg::BURST_W-1:0]   done_count;
   logic [fbf_pkg::FILL_W-1:0]    fill_level;
   logic                          not_full;
   logic                          not_almost_full;
   logic                          not_empty;
   logic                          not_almost_empty;
   logic                          overrun_flag;
   logic                          underrun_flag;

   modport source (
      output valid, read_bytes, done_count, fill_level, not_full, not_almost_full,
             not_empty, not_almost_empty, overrun_flag, underrun_flag,
      input  ready
   );
   modport sink (
      input  valid, read_bytes, done_count, fill_level, not_full, not_almost_full,
             not_empty, not_almost_empty, overrun_flag, underrun_flag,
      output ready
   );
endinterface

// File: src/fbf_lane.sv
// one byte lane of a burst: holds the byte to write or the byte read back
// depends on fbf_pkg for the step counter width
module fbf_lane #(
   parameter int LANE_IDX = 0
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [7:0]                    load_byte,
   input  logic [fbf_pkg::BURST_W-1:0]   step,
   input  logic                          rd_hit,
   input  logic [fbf_pkg::BURST_W-1:0]   rd_step,
   input  logic [7:0]                    rd_byte,
   output logic [7:0]                    wr_byte,
   output logic [7:0]                    held_byte
);

   localparam int BW = fbf_pkg::BURST_W;
   localparam logic [BW-1:0] MY_STEP = BW'(LANE_IDX);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // load at acceptance, catch the memory byte that belongs to this lane
   always_comb begin
      byte_in = byte_ff;
      if (load) begin
         byte_in = load_byte;
      end else if (rd_hit && (rd_step == MY_STEP)) begin
         byte_in = rd_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // offer the byte to the memory only on this lane's step
   assign wr_byte   = (step == MY_STEP) ? byte_ff : 8'h00;
   assign held_byte = byte_ff;

endmodule

// File: src/fbf_merge.sv
// merge stage: gathers the lane bytes, works out the level flags, registers the result
// depends on fbf_pkg for the status and result structs
module fbf_merge #(
   parameter int MAX_BURST = 8
) (
   input  logic                          clock,
   input  logic                          load,
   input  fbf_pkg::status_type           status,
   input  logic [8*MAX_BURST-1:0]        lane_bytes,
   output fbf_pkg::rsp_type              rsp
);

   localparam int DW = fbf_pkg::DATA_W;
   localparam int FW = fbf_pkg::FILL_W;

   fbf_pkg::rsp_type rsp_ff;
   fbf_pkg::rsp_type rsp_in;

   logic          show_rd;
   logic [FW-1:0] margin_ext;
   logic          full;
   logic          afull;
   logic          empty;
   logic          aempty;

   // level flags after the operation
   always_comb begin
      margin_ext = FW'(status.margin);
      full       = (status.fill >= status.depth);
      afull      = full || ((margin_ext <= status.depth) &&
                            (status.fill == (status.depth - margin_ext)));
      empty      = (status.fill == '0);
      aempty     = empty || (status.fill == margin_ext);
      show_rd    = (status.op == fbf_pkg::OP_READ) || (status.op == fbf_pkg::OP_PEEK);
   end

   // lane bytes only reach the result for reads and peeks
   always_comb begin
      rsp_in.read_bytes       = show_rd ? DW'(lane_bytes) : '0;
      rsp_in.done_count       = status.done;
      rsp_in.fill_level       = status.fill;
      rsp_in.not_full         = !full;
      rsp_in.not_almost_full  = !afull;
      rsp_in.not_empty        = !empty;
      rsp_in.not_almost_empty = !aempty;
      rsp_in.overrun_flag     = status.overrun;
      rsp_in.underrun_flag    = status.underrun;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: src/byte_fifo_burst_flags.sv
// burst byte fifo top level: sequencer, byte-wide ring memory, lanes and merge stage
// sequence: an accepted item passes run, drain and finish, where the result is registered;
// one that moves nothing goes straight to finish. Items are taken only in idle; one byte
// per cycle uses the single memory port; a result left waiting holds the next in finish
// reset: synchronous; pointers, fill and sticky flags clear, depth 256, margin 1, store kept
// depends on fbf_pkg, fbf_req_if, fbf_rsp_if, fbf_lane, fbf_merge and the defines header
`include "byte_fifo_burst_flags_defines.svh"

module byte_fifo_burst_flags #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   fbf_req_if.sink                          req_ch,
   fbf_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [fbf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbf_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   localparam int BW    = fbf_pkg::BURST_W;
   localparam int FW    = fbf_pkg::FILL_W;
   localparam int MW    = fbf_pkg::MARGIN_W;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int EXT_W = (PTR_W + 1 > FW + 1) ? PTR_W + 1 : FW + 1;
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);
   localparam logic [BW-1:0]    BURST_MAX = BW'(MAX_BURST);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [FW-1:0]          depth_ff, depth_in;
   logic [MW-1:0]          margin_ff, margin_in;
   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic [PTR_W-1:0]       rp_ff, rp_in;
   logic [PTR_W-1:0]       scan_ff, scan_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic                   ovr_ff, ovr_in;
   logic                   unr_ff, unr_in;
   fbf_pkg::op_type        op_ff, op_in;
   logic [BW-1:0]          done_ff, done_in;
   logic [BW-1:0]          step_ff, step_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [BW-1:0]          rd_step_ff, rd_step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rd_data_ff;
   logic [7:0]             byte_store_ff [DEPTH];

   logic [EXT_W-1:0]       depth_ext;
   logic [EXT_W-1:0]       d_ext;
   logic [EXT_W-1:0]       fill_ext;
   logic [EXT_W-1:0]       room;
   logic [EXT_W-1:0]       cnt_ext;
   logic [BW-1:0]          cnt;
   fbf_pkg::op_type        acc_op;
   logic [BW-1:0]          acc_done;
   logic                   accept;
   logic                   last_step;
   logic                   load_rsp;
   logic                   mem_we;
   logic [7:0]             wr_byte;
   logic [7:0]             lane_wr [MAX_BURST];
   logic [8*MAX_BURST-1:0] lane_bytes;
   fbf_pkg::status_type    status;
   fbf_pkg::rsp_type       rsp;

   // ring step that wraps at the depth in use
   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p,
                                                 input logic [EXT_W-1:0] d);
      logic [EXT_W-1:0] p1;
      p1 = EXT_W'(p) + EXT_W'(1);
      ptr_step = (p1 >= d) ? '0 : PTR_W'(p1);
   endfunction

   // depth in use, held within 1 and DEPTH
   always_comb begin
      depth_ext = EXT_W'(depth_ff);
      if (depth_ff == '0) begin
         d_ext = EXT_W'(1);
      end else if (depth_ext > DEPTH_EXT) begin
         d_ext = DEPTH_EXT;
      end else begin
         d_ext = depth_ext;
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // burst length and bytes moved, decided when the item is accepted
   always_comb begin
      acc_op   = fbf_pkg::op_type'(req_ch.req_type);
      cnt      = (req_ch.byte_count > BURST_MAX) ? BURST_MAX : req_ch.byte_count;
      cnt_ext  = EXT_W'(cnt);
      fill_ext = EXT_W'(fill_ff);
      room     = d_ext - fill_ext;
      acc_done = '0;
      ovr_in   = ovr_ff;
      unr_in   = unr_ff;
      fill_in  = fill_ff;
      if (accept) begin
         if (req_ch.clear_overrun) begin
            ovr_in = 1'b0;
         end
         if (req_ch.clear_underrun) begin
            unr_in = 1'b0;
         end
         case (acc_op)
            fbf_pkg::OP_WRITE: begin
               if (cnt != '0) begin
                  if (fill_ext >= d_ext) begin
                     ovr_in = 1'b1;
                  end else begin
                     acc_done = (cnt_ext < room) ? cnt : BW'(room);
                     fill_in  = fill_ff + FW'(acc_done);
                  end
               end
            end
            fbf_pkg::OP_ADVANCE: begin
               if (fill_ff == '0) begin
                  unr_in = 1'b1;
               end else begin
                  acc_done = (cnt_ext < fill_ext) ? cnt : BW'(fill_ff);
                  fill_in  = fill_ff - FW'(acc_done);
               end
            end
            fbf_pkg::OP_READ, fbf_pkg::OP_PEEK: begin
               if (cnt != '0) begin
                  if (fill_ff == '0) begin
                     if (acc_op == fbf_pkg::OP_READ) begin
                        unr_in = 1'b1;
                     end
                  end else begin
                     acc_done = (cnt_ext < fill_ext) ? cnt : BW'(fill_ff);
                     if (acc_op == fbf_pkg::OP_READ) begin
                        fill_in = fill_ff - FW'(acc_done);
                     end
                  end
               end
            end
            default: begin
               acc_done = '0;
            end
         endcase
      end
   end

   // sequencer: one byte of the burst per cycle through the ring memory
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      scan_in      = scan_ff;
      op_in        = op_ff;
      done_in      = done_ff;
      step_in      = step_ff;
      rd_pend_in   = 1'b0;
      rd_step_in   = rd_step_ff;
      load_rsp     = 1'b0;
      mem_we       = 1'b0;
      last_step    = ((step_ff + BW'(1)) == done_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = acc_op;
               done_in  = acc_done;
               step_in  = '0;
               scan_in  = rp_ff;
               state_in = (acc_done == '0) ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (op_ff == fbf_pkg::OP_WRITE) begin
               mem_we = 1'b1;
               wp_in  = ptr_step(wp_ff, d_ext);
            end else begin
               scan_in = ptr_step(scan_ff, d_ext);
            end
            rd_pend_in = (op_ff == fbf_pkg::OP_READ) || (op_ff == fbf_pkg::OP_PEEK);
            rd_step_in = step_ff;
            step_in    = step_ff + BW'(1);
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               if ((op_ff == fbf_pkg::OP_READ) || (op_ff == fbf_pkg::OP_ADVANCE)) begin
                  rp_in = scan_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      depth_in  = depth_ff;
      margin_in = margin_ff;
      if (csr_we) begin
         case (csr_index)
            fbf_pkg::CSR_DEPTH:  depth_in  = csr_wdata;
            fbf_pkg::CSR_MARGIN: margin_in = csr_wdata[MW-1:0];
            default: begin
               depth_in = depth_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= fbf_pkg::DEPTH_RESET;
         margin_ff    <= fbf_pkg::MARGIN_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         ovr_ff       <= 1'b0;
         unr_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         margin_ff    <= margin_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         ovr_ff       <= ovr_in;
         unr_ff       <= unr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-item registers
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      op_ff      <= op_in;
      done_ff    <= done_in;
      step_ff    <= step_in;
      rd_step_ff <= rd_step_in;
   end

   // byte-wide ring memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store_ff[wp_ff] <= wr_byte;
      end
      rd_data_ff <= byte_store_ff[scan_ff];
   end

   // byte lanes of the burst
   for (genvar gi = 0; gi < MAX_BURST; gi++) begin : g_lane
      fbf_lane #(
         .LANE_IDX (gi)
      ) u_lane (
         .clock     (clock),
         .load      (accept),
         .load_byte ((acc_op == fbf_pkg::OP_WRITE) ? req_ch.write_bytes[8*gi +: 8] : 8'h00),
         .step      (step_ff),
         .rd_hit    (rd_pend_ff),
         .rd_step   (rd_step_ff),
         .rd_byte   (rd_data_ff),
         .wr_byte   (lane_wr[gi]),
         .held_byte (lane_bytes[8*gi +: 8])
      );
   end

   // only the lane on the current step drives a byte
   always_comb begin
      wr_byte = 8'h00;
      for (int i = 0; i < MAX_BURST; i++) begin
         wr_byte = wr_byte | lane_wr[i];
      end
   end

   // status handed to the merge stage
   always_comb begin
      status.op       = op_ff;
      status.done     = done_ff;
      status.fill     = fill_ff;
      status.depth    = FW'(d_ext);
      status.margin   = margin_ff;
      status.overrun  = ovr_ff;
      status.underrun = unr_ff;
   end

   fbf_merge #(
      .MAX_BURST (MAX_BURST)
   ) u_merge (
      .clock      (clock),
      .load       (load_rsp),
      .status     (status),
      .lane_bytes (lane_bytes),
      .rsp        (rsp)
   );

   // result channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.read_bytes       = rsp.read_bytes;
   assign rsp_ch.done_count       = rsp.done_count;
   assign rsp_ch.fill_level       = rsp.fill_level;
   assign rsp_ch.not_full         = rsp.not_full;
   assign rsp_ch.not_almost_full  = rsp.not_almost_full;
   assign rsp_ch.not_empty        = rsp.not_empty;
   assign rsp_ch.not_almost_empty = rsp.not_almost_empty;
   assign rsp_ch.overrun_flag     = rsp.overrun_flag;
   assign rsp_ch.underrun_flag    = rsp.underrun_flag;

   // checks
   `FBF_ASSERT(a_accept_starts, clock, reset, accept |=> (state_ff == ST_RUN || state_ff == ST_FINISH), "accepted item did not start")
   `FBF_ASSERT(a_rsp_not_lost, clock, reset, (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_FINISH && rsp_valid_ff), "waiting result overwritten")
   `FBF_ASSERT(a_rd_in_burst, clock, reset, rd_pend_ff |-> (state_ff == ST_RUN || state_ff == ST_DRAIN), "memory read outside a burst")
   `FBF_ASSERT_ALWAYS(a_done_bound, clock, (state_ff == ST_RUN) |-> (done_ff <= BURST_MAX && done_ff != '0), "burst length out of range")

endmodule
